// ===== sv/dtq_pkg.sv =====
// Package: shared constants and state type of the deadline timer queue.
package dtq_pkg;

  localparam int SEQ_BITS    = 16;
  localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;
  localparam int MAX_RESULTS = 32;
  localparam int RES_W       = 6;

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_WR,
    ST_ACK,
    ST_RN_I,
    ST_RN_IW,
    ST_RN_SCAN,
    ST_RN_COPY,
    ST_SCAN,
    ST_DECIDE,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_NEXT,
    ST_FLUSH
  } state_t;

endpackage

// ===== sv/dtq_if.sv =====
// Interfaces: request and result channels of the deadline timer queue.
interface dtq_req_if #(
  parameter int TIME_BITS = 32,
  parameter int TAG_BITS  = 16
);
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [TIME_BITS-1:0] timeout;
  logic [TAG_BITS-1:0]  action_tag;
  logic                 has_action;
  logic [TIME_BITS-1:0] current_time;

  modport source (output valid, opcode, timeout, action_tag, has_action, current_time,
                  input ready);
  modport sink   (input valid, opcode, timeout, action_tag, has_action, current_time,
                  output ready);
endinterface

interface dtq_rsp_if #(
  parameter int TIME_BITS = 32,
  parameter int TAG_BITS  = 16
);
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic                 status;
  logic [TAG_BITS-1:0]  released_tag;
  logic [TIME_BITS-1:0] released_deadline;
  logic                 missing_action;
  logic                 last;

  modport source (output valid, kind, status, released_tag, released_deadline,
                  missing_action, last, input ready);
  modport sink   (input valid, kind, status, released_tag, released_deadline,
                  missing_action, last, output ready);
endinterface

// ===== sv/dtq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/deadline_timer_queue_unit.sv =====
// Top level: deadline timer queue with entries held in one RAM, plus a rank scratch RAM.
//
// Entries occupy slots 0..count-1 of the entry RAM. A push writes its entry and then waits for
// the result slot. An update scans all live entries through the single RAM read port for
// every released entry, and returns straight to idle when the queue is empty. Once every 65535
// pushes the sequence numbers are compacted before the push, ranking each live entry by a
// full scan through the read port.
// The next transaction is accepted only when the block is back in its idle state.
module deadline_timer_queue_unit
  import dtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int TIME_BITS   = 32,
  parameter int TAG_BITS    = 16
) (
  input logic    clk,
  input logic    rst,
  dtq_req_if.sink   req,
  dtq_rsp_if.source rsp
);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int E_W   = TIME_BITS + TAG_BITS + 1 + SEQ_BITS;

  state_t state, state_next;

  logic [TIME_BITS-1:0] now_time;
  logic [CNT_W-1:0]     count;
  logic [SEQ_BITS-1:0]  nseq;
  logic [TIME_BITS-1:0] p_timeout;
  logic [TAG_BITS-1:0]  p_tag;
  logic                 p_has;
  logic                 p_full;

  logic [CNT_W-1:0] scan_idx;
  logic             pv;
  logic [IDX_W-1:0] pidx;
  logic             issue, scan_done;

  logic [TIME_BITS-1:0] best_d;
  logic [SEQ_BITS-1:0]  best_s;
  logic [TAG_BITS-1:0]  best_tag;
  logic                 best_has;
  logic [IDX_W-1:0]     best_idx;

  logic                 have_pend;
  logic [TIME_BITS-1:0] pend_d;
  logic [TAG_BITS-1:0]  pend_tag;
  logic                 pend_has;
  logic [RES_W-1:0]     nres;

  logic [CNT_W-1:0]    ri;
  logic [SEQ_BITS-1:0] seq_i;
  logic [CNT_W-1:0]    rank_acc;

  logic             we, rk_we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [E_W-1:0]   wdata, rdata;
  logic [CNT_W-1:0] rk_rdata;

  logic [TIME_BITS-1:0] r_d;
  logic [TAG_BITS-1:0]  r_tag;
  logic                 r_has;
  logic [SEQ_BITS-1:0]  r_s;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] sat;
  logic                 earlier, out_free, expired, need_move;
  logic                 emit;
  logic                 e_kind, e_status, e_missing, e_last;
  logic [TAG_BITS-1:0]  e_tag;
  logic [TIME_BITS-1:0] e_d;

  assign {r_d, r_tag, r_has, r_s} = rdata;
  assign sum = {1'b0, now_time} + {1'b0, p_timeout};
  assign sat = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign earlier = (r_d < best_d) || ((r_d == best_d) && (r_s < best_s));
  assign out_free = !rsp.valid || rsp.ready;
  assign issue = scan_idx < count;
  assign scan_done = !issue && !pv;
  assign expired = best_d < now_time;
  assign need_move = CNT_W'(best_idx) != (count - CNT_W'(1));

  dtq_ram #(.WIDTH(E_W), .DEPTH(QUEUE_DEPTH)) u_entry_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  dtq_ram #(.WIDTH(CNT_W), .DEPTH(QUEUE_DEPTH)) u_rank_ram (
    .clk(clk), .we(rk_we), .waddr(ri[IDX_W-1:0]), .wdata(rank_acc),
    .raddr(scan_idx[IDX_W-1:0]), .rdata(rk_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req.opcode == OP_UPDATE) begin
            state_next = (count == '0) ? ST_IDLE : ST_SCAN;
          end else if (count == CNT_W'(QUEUE_DEPTH)) begin
            state_next = ST_ACK;
          end else if (nseq == SEQ_MAX && count != '0) begin
            state_next = ST_RN_I;
          end else begin
            state_next = ST_PUSH_WR;
          end
        end
      end
      ST_PUSH_WR: state_next = ST_ACK;
      ST_ACK:     if (out_free) state_next = ST_IDLE;
      ST_RN_I:    state_next = ST_RN_IW;
      ST_RN_IW:   state_next = ST_RN_SCAN;
      ST_RN_SCAN: begin
        if (scan_done) begin
          state_next = (ri + CNT_W'(1) == count) ? ST_RN_COPY : ST_RN_I;
        end
      end
      ST_RN_COPY: if (scan_done) state_next = ST_PUSH_WR;
      ST_SCAN:    if (scan_done) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (!expired) begin
          state_next = ST_FLUSH;
        end else if (!have_pend || out_free) begin
          state_next = need_move ? ST_MOVE_RD : ST_NEXT;
        end
      end
      ST_MOVE_RD: state_next = ST_MOVE_WR;
      ST_MOVE_WR: state_next = ST_NEXT;
      ST_NEXT: begin
        state_next = (nres == RES_W'(MAX_RESULTS) || count == '0) ? ST_FLUSH : ST_SCAN;
      end
      ST_FLUSH:   if (!have_pend || out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    we        = 1'b0;
    waddr     = count[IDX_W-1:0];
    wdata     = {sat, p_tag, p_has, nseq};
    raddr     = scan_idx[IDX_W-1:0];
    rk_we     = 1'b0;
    emit      = 1'b0;
    e_kind    = KIND_ACK;
    e_status  = STATUS_OK;
    e_tag     = '0;
    e_d       = '0;
    e_missing = 1'b0;
    e_last    = 1'b1;
    unique case (state)
      ST_PUSH_WR: we = 1'b1;
      ST_ACK: begin
        emit     = out_free;
        e_status = p_full ? STATUS_FULL : STATUS_OK;
      end
      ST_RN_I:    raddr = ri[IDX_W-1:0];
      ST_RN_SCAN: rk_we = scan_done;
      ST_RN_COPY: begin
        we    = pv;
        waddr = pidx;
        wdata = {rdata[E_W-1:SEQ_BITS], SEQ_BITS'(rk_rdata)};
      end
      ST_DECIDE: begin
        emit      = expired && have_pend && out_free;
        e_kind    = KIND_RELEASE;
        e_tag     = pend_tag;
        e_d       = pend_d;
        e_missing = !pend_has;
        e_last    = 1'b0;
      end
      ST_MOVE_RD: raddr = count[IDX_W-1:0];
      ST_MOVE_WR: begin
        we    = 1'b1;
        waddr = best_idx;
        wdata = rdata;
      end
      ST_FLUSH: begin
        emit      = have_pend && out_free;
        e_kind    = KIND_RELEASE;
        e_tag     = pend_tag;
        e_d       = pend_d;
        e_missing = !pend_has;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      now_time  <= '0;
      count     <= '0;
      nseq      <= '0;
      rsp.valid <= 1'b0;
      have_pend <= 1'b0;
      pv        <= 1'b0;
      scan_idx  <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        rsp.valid             <= 1'b1;
        rsp.kind              <= e_kind;
        rsp.status            <= e_status;
        rsp.released_tag      <= e_tag;
        rsp.released_deadline <= e_d;
        rsp.missing_action    <= e_missing;
        rsp.last              <= e_last;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      if (state == ST_SCAN || state == ST_RN_SCAN || state == ST_RN_COPY) begin
        pv   <= issue;
        pidx <= scan_idx[IDX_W-1:0];
        if (scan_done) scan_idx <= '0;
        else if (issue) scan_idx <= scan_idx + CNT_W'(1);
      end else begin
        pv       <= 1'b0;
        scan_idx <= '0;
      end

      unique case (state)
        ST_IDLE: begin
          p_timeout <= req.timeout;
          p_tag     <= req.action_tag;
          p_has     <= req.has_action;
          p_full    <= (count == CNT_W'(QUEUE_DEPTH));
          ri        <= '0;
          nres      <= '0;
          have_pend <= 1'b0;
          if (req.valid) begin
            if (req.opcode == OP_UPDATE) begin
              now_time <= req.current_time;
            end else if (nseq == SEQ_MAX && count == '0) begin
              nseq <= '0;
            end
          end
        end
        ST_PUSH_WR: begin
          count <= count + CNT_W'(1);
          nseq  <= nseq + SEQ_BITS'(1);
        end
        ST_RN_IW: begin
          seq_i    <= r_s;
          rank_acc <= '0;
        end
        ST_RN_SCAN: begin
          if (pv && r_s < seq_i) rank_acc <= rank_acc + CNT_W'(1);
          if (scan_done) ri <= ri + CNT_W'(1);
        end
        ST_RN_COPY: if (scan_done) nseq <= SEQ_BITS'(count);
        ST_SCAN: begin
          if (pv && (pidx == '0 || earlier)) begin
            best_d   <= r_d;
            best_s   <= r_s;
            best_tag <= r_tag;
            best_has <= r_has;
            best_idx <= pidx;
          end
        end
        ST_DECIDE: begin
          if (expired && (!have_pend || out_free)) begin
            have_pend <= 1'b1;
            pend_d    <= best_d;
            pend_tag  <= best_tag;
            pend_has  <= best_has;
            nres      <= nres + RES_W'(1);
            count     <= count - CNT_W'(1);
          end
        end
        ST_FLUSH: if (out_free) have_pend <= 1'b0;
        default: ;
      endcase
    end
  end
endmodule

// ===== tb/deadline_timer_queue_unit_tb.sv =====
// Testbench: randomized and directed check of the deadline timer queue against a queue predictor.
`timescale 1ns / 1ps

module deadline_timer_queue_unit_tb
  import dtq_pkg::*;
;

  typedef struct packed {
    logic        opcode;
    logic [31:0] timeout;
    logic [15:0] action_tag;
    logic        has_action;
    logic [31:0] current_time;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic        status;
    logic [15:0] released_tag;
    logic [31:0] released_deadline;
    logic        missing_action;
    logic        last;
  } rsp_t;

  localparam int DEPTH = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dtq_req_if req ();
  dtq_rsp_if rsp ();

  deadline_timer_queue_unit u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [31:0] now_q;
  logic [31:0] dl_q[DEPTH];
  logic [15:0] tag_q[DEPTH];
  logic        act_q[DEPTH];
  int unsigned seq_q[DEPTH];
  int unsigned live_n;
  int unsigned seq_next;

  req_t pending_req[$];
  rsp_t expected_rsp[$];
  int   errors = 0;
  int   n_push = 0, n_full = 0, n_release = 0;
  bit   quiet = 1'b0;

  function automatic rsp_t mk_rsp(logic k, logic s, logic [15:0] t, logic [31:0] d,
                                  logic m, logic l);
    rsp_t r;
    r.kind = k; r.status = s; r.released_tag = t; r.released_deadline = d;
    r.missing_action = m; r.last = l;
    return r;
  endfunction

  task automatic predict_queue(input req_t it);
    logic [32:0] sum;
    int unsigned rank[DEPTH];
    int best, n;
    if (it.opcode == OP_PUSH) begin
      if (live_n >= DEPTH) begin
        expected_rsp.push_back(mk_rsp(KIND_ACK, STATUS_FULL, '0, '0, 1'b0, 1'b1));
        return;
      end
      if (seq_next >= 32'hFFFF) begin
        for (int i = 0; i < live_n; i++) begin
          rank[i] = 0;
          for (int j = 0; j < live_n; j++)
            if (seq_q[j] < seq_q[i]) rank[i]++;
        end
        for (int i = 0; i < live_n; i++) seq_q[i] = rank[i];
        seq_next = live_n;
      end
      sum = {1'b0, now_q} + {1'b0, it.timeout};
      dl_q[live_n] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      tag_q[live_n] = it.action_tag;
      act_q[live_n] = it.has_action;
      seq_q[live_n] = seq_next;
      seq_next = (seq_next + 1) & 32'hFFFF;
      live_n++;
      expected_rsp.push_back(mk_rsp(KIND_ACK, STATUS_OK, '0, '0, 1'b0, 1'b1));
      return;
    end
    now_q = it.current_time;
    n = 0;
    while (n < MAX_RESULTS && live_n > 0) begin
      best = 0;
      for (int i = 1; i < live_n; i++)
        if (dl_q[i] < dl_q[best] || (dl_q[i] == dl_q[best] && seq_q[i] < seq_q[best]))
          best = i;
      if (dl_q[best] >= now_q) break;
      expected_rsp.push_back(mk_rsp(KIND_RELEASE, STATUS_OK, tag_q[best], dl_q[best],
                                    !act_q[best], 1'b0));
      n++;
      live_n--;
      dl_q[best] = dl_q[live_n]; tag_q[best] = tag_q[live_n];
      act_q[best] = act_q[live_n]; seq_q[best] = seq_q[live_n];
    end
    if (n > 0) expected_rsp[$].last = 1'b1;
  endtask

  function automatic req_t push_item(logic [31:0] to, logic [15:0] tg, logic ha);
    req_t r;
    r.opcode = OP_PUSH; r.timeout = to; r.action_tag = tg; r.has_action = ha;
    r.current_time = $urandom;
    return r;
  endfunction

  function automatic req_t update_item(logic [31:0] ct);
    req_t r;
    r.opcode = OP_UPDATE; r.timeout = $urandom; r.action_tag = 16'($urandom);
    r.has_action = 1'($urandom); r.current_time = ct;
    return r;
  endfunction

  // driver
  initial begin
    req.valid = 1'b0; req.opcode = 1'b0; req.timeout = '0; req.action_tag = '0;
    req.has_action = 1'b0; req.current_time = '0;
  end

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (req.valid) predict_queue(req_t'({req.opcode, req.timeout, req.action_tag,
                                           req.has_action, req.current_time}));
      if (pending_req.size() > 0 && (quiet || $urandom_range(99) >= 11)) begin
        req_t it;
        it = pending_req.pop_front();
        req.valid <= 1'b1;
        req.opcode <= it.opcode; req.timeout <= it.timeout;
        req.action_tag <= it.action_tag; req.has_action <= it.has_action;
        req.current_time <= it.current_time;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp_t got, exp_r;
        got = mk_rsp(rsp.kind, rsp.status, rsp.released_tag, rsp.released_deadline,
                     rsp.missing_action, rsp.last);
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
          errors++;
        end else begin
          exp_r = expected_rsp.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, got);
            errors++;
          end
          if (got.kind == KIND_RELEASE) n_release++;
          else if (got.status == STATUS_FULL) n_full++;
          else n_push++;
        end
      end
      rsp.ready <= quiet || ($urandom_range(99) >= 11);
    end
  end

  initial rsp.ready = 1'b0;

  task automatic wait_drained();
    while (pending_req.size() > 0 || req.valid || expected_rsp.size() > 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] t;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed
    pending_req.push_back(update_item(32'h0));
    pending_req.push_back(push_item(32'h0, 16'h0000, 1'b0));
    pending_req.push_back(push_item(32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    pending_req.push_back(push_item(32'h0001_0000, 16'h1234, 1'b1));
    pending_req.push_back(push_item(32'h0001_0000, 16'h4321, 1'b0));
    pending_req.push_back(update_item(32'h0000_8000));
    pending_req.push_back(update_item(32'h0001_0001));
    pending_req.push_back(push_item(32'hFFFF_FFFF, 16'h5555, 1'b0));
    pending_req.push_back(update_item(32'hFFFF_FFFF));
    pending_req.push_back(update_item(32'h0000_0010));
    pending_req.push_back(update_item(32'h0000_0000));
    wait_drained();

    // fill past capacity, then release every expired entry in one update
    for (int i = 0; i < DEPTH + 2; i++)
      pending_req.push_back(push_item($urandom_range(8), 16'($urandom), 1'($urandom)));
    pending_req.push_back(update_item(32'hFFFF_FFFF));
    pending_req.push_back(update_item(32'h0000_0000));
    wait_drained();

    // random: bursts of pushes then an update, small times near now
    t = 32'h0;
    while (pending_req.size() < 150) begin
      int k;
      k = $urandom_range(1, 8);
      for (int i = 0; i < k; i++) begin
        case ($urandom_range(9))
          0: pending_req.push_back(push_item($urandom, 16'($urandom), 1'($urandom)));
          1: pending_req.push_back(push_item(32'hFFFF_FFFF - $urandom_range(3),
                                             16'($urandom), 1'($urandom)));
          default: pending_req.push_back(push_item($urandom_range(400), 16'($urandom),
                                                   1'($urandom)));
        endcase
      end
      case ($urandom_range(9))
        0: t = $urandom;
        1: t = t - $urandom_range(100);
        default: t = t + $urandom_range(300);
      endcase
      pending_req.push_back(update_item(t));
    end
    quiet = 1'b1;
    repeat (60) @(posedge clk);
    quiet = 1'b0;
    wait_drained();
    pending_req.push_back(update_item(32'hFFFF_FFFF));
    wait_drained();
    repeat (300) @(posedge clk);
    $display("acks %0d, full rejects %0d, releases %0d", n_push, n_full, n_release);
    if (errors == 0 && expected_rsp.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

endmodule
